// File: src/i2crm_pkg.sv
package i2crm_pkg;

   // Request codes carried in the mode field.
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_TICKS_PER_US = 1'b0;
   localparam logic CSR_ACK_TIMEOUT  = 1'b1;

   // Configuration register reset values.
   localparam logic [7:0] TICKS_PER_US_RESET = 8'd1;
   localparam logic [7:0] ACK_TIMEOUT_RESET  = 8'd250;

   // The device address is sent with this bit set in the read phase.
   localparam logic [7:0] READ_BIT = 8'h01;

   // One input item.
   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] wr_data;
      logic       sda_in;
   } req_type;

   // One result item.
   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_oe;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rd_data;
      logic       ack_error;
   } rsp_type;

endpackage

// File: src/i2crm_core.sv
module i2crm_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  i2crm_pkg::req_type  req,
   input  logic [7:0]          ticks_per_us,
   input  logic [7:0]          ack_timeout,
   output i2crm_pkg::rsp_type  rsp
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_START_A, PH_START_B, PH_TX_LOW, PH_TX_HIGH, PH_TX_TAIL,
      PH_ACK_SETUP, PH_ACK_RISE, PH_ACK_POLL, PH_RX_LOW, PH_RX_HIGH,
      PH_NACK_LOW, PH_NACK_HIGH, PH_STOP_LOW, PH_STOP_HIGH
   } phase_type;

   typedef enum logic [2:0] {
      ST_DEV_W, ST_REG, ST_DATA, ST_DEV_R, ST_READ
   } stage_type;

   phase_type  phase_ff, phase_in;
   stage_type  stage_ff, stage_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [9:0] delay_ff, delay_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] wait_ff, wait_in;
   logic [7:0] saved_dev_ff, saved_dev_in;
   logic [7:0] saved_reg_ff, saved_reg_in;
   logic [7:0] saved_data_ff, saved_data_in;
   logic       is_read_ff, is_read_in;
   logic [7:0] read_result_ff, read_result_in;
   logic       error_ff, error_in;

   logic [7:0] tick_unit;
   logic [9:0] delay_1, delay_2, delay_4;
   logic [3:0] bit_count_inc;
   logic       done;
   logic       scl, sda, oe;
   logic       command;

   // A zero tick count behaves as one; delays of one, two and four units are shifts.
   assign tick_unit     = (ticks_per_us == 8'd0) ? 8'd1 : ticks_per_us;
   assign delay_1       = {2'b00, tick_unit};
   assign delay_2       = {1'b0, tick_unit, 1'b0};
   assign delay_4       = {tick_unit, 2'b00};
   assign bit_count_inc = bit_count_ff + 4'd1;
   assign command       = (req.mode == i2crm_pkg::MODE_READ) ||
                          (req.mode == i2crm_pkg::MODE_WRITE);

   // Line levels follow the phase held before this item.
   always_comb begin
      scl = 1'b1;
      sda = 1'b1;
      oe  = 1'b1;
      case (phase_ff)
         PH_START_B:   sda = 1'b0;
         PH_TX_LOW:    begin scl = 1'b0; sda = shift_ff[7]; end
         PH_TX_HIGH:   sda = shift_ff[7];
         PH_TX_TAIL:   begin scl = 1'b0; sda = shift_ff[7]; end
         PH_ACK_SETUP: begin scl = 1'b0; oe = 1'b0; end
         PH_ACK_RISE:  oe = 1'b0;
         PH_ACK_POLL:  oe = 1'b0;
         PH_RX_HIGH:   oe = 1'b0;
         PH_RX_LOW:    begin scl = 1'b0; oe = 1'b0; end
         PH_NACK_LOW:  scl = 1'b0;
         PH_STOP_LOW:  begin scl = 1'b0; sda = 1'b0; end
         default:      ;
      endcase
   end

   // Next state for one item.
   always_comb begin
      phase_in       = phase_ff;
      stage_in       = stage_ff;
      bit_count_in   = bit_count_ff;
      delay_in       = delay_ff;
      shift_in       = shift_ff;
      wait_in        = wait_ff;
      saved_dev_in   = saved_dev_ff;
      saved_reg_in   = saved_reg_ff;
      saved_data_in  = saved_data_ff;
      is_read_in     = is_read_ff;
      read_result_in = read_result_ff;
      error_in       = error_ff;
      done           = 1'b0;

      if (phase_ff == PH_IDLE) begin
         // A command in idle latches its operands and opens the start condition.
         if (command) begin
            saved_dev_in  = req.dev_addr;
            saved_reg_in  = req.reg_addr;
            saved_data_in = req.wr_data;
            is_read_in    = (req.mode == i2crm_pkg::MODE_READ);
            error_in      = 1'b0;
            stage_in      = ST_DEV_W;
            shift_in      = req.dev_addr;
            bit_count_in  = 4'd0;
            wait_in       = 8'd0;
            phase_in      = PH_START_A;
            delay_in      = delay_4;
         end
      end else if (phase_ff == PH_ACK_POLL) begin
         // Wait for the target to pull the data line low.
         if (!req.sda_in) begin
            case (stage_ff)
               ST_DEV_W: begin
                  stage_in     = ST_REG;
                  shift_in     = saved_reg_ff;
                  bit_count_in = 4'd0;
                  phase_in     = PH_TX_LOW;
                  delay_in     = delay_2;
               end
               ST_REG: begin
                  bit_count_in = 4'd0;
                  if (is_read_ff) begin
                     stage_in = ST_DEV_R;
                     shift_in = saved_dev_ff | i2crm_pkg::READ_BIT;
                     phase_in = PH_START_A;
                     delay_in = delay_4;
                  end else begin
                     stage_in = ST_DATA;
                     shift_in = saved_data_ff;
                     phase_in = PH_TX_LOW;
                     delay_in = delay_2;
                  end
               end
               ST_DEV_R: begin
                  stage_in     = ST_READ;
                  shift_in     = 8'd0;
                  bit_count_in = 4'd0;
                  phase_in     = PH_RX_LOW;
                  delay_in     = delay_2;
               end
               default: begin
                  phase_in = PH_STOP_LOW;
                  delay_in = delay_4;
               end
            endcase
         end else if (wait_ff >= ack_timeout) begin
            error_in = 1'b1;
            phase_in = PH_STOP_LOW;
            delay_in = delay_4;
         end else begin
            wait_in = wait_ff + 8'd1;
         end
      end else if (delay_ff > 10'd1) begin
         delay_in = delay_ff - 10'd1;
      end else begin
         case (phase_ff)
            PH_START_A: begin
               phase_in = PH_START_B;
               delay_in = delay_4;
            end
            PH_START_B: begin
               bit_count_in = 4'd0;
               phase_in     = PH_TX_LOW;
               delay_in     = delay_2;
            end
            PH_TX_LOW: begin
               phase_in = PH_TX_HIGH;
               delay_in = delay_2;
            end
            PH_TX_HIGH: begin
               phase_in = PH_TX_TAIL;
               delay_in = delay_2;
            end
            PH_TX_TAIL: begin
               shift_in     = {shift_ff[6:0], 1'b0};
               bit_count_in = bit_count_inc;
               if (bit_count_inc >= 4'd8) begin
                  wait_in  = 8'd0;
                  phase_in = PH_ACK_SETUP;
                  delay_in = delay_1;
               end else begin
                  phase_in = PH_TX_LOW;
                  delay_in = delay_2;
               end
            end
            PH_ACK_SETUP: begin
               phase_in = PH_ACK_RISE;
               delay_in = delay_1;
            end
            PH_ACK_RISE: begin
               phase_in = PH_ACK_POLL;
               delay_in = 10'd0;
            end
            PH_RX_LOW: begin
               phase_in = PH_RX_HIGH;
               delay_in = delay_1;
            end
            PH_RX_HIGH: begin
               // Sample on the last tick of the clock-high interval.
               shift_in     = {shift_ff[6:0], req.sda_in};
               bit_count_in = bit_count_inc;
               if (bit_count_inc >= 4'd8) begin
                  read_result_in = {shift_ff[6:0], req.sda_in};
                  phase_in       = PH_NACK_LOW;
                  delay_in       = delay_2;
               end else begin
                  phase_in = PH_RX_LOW;
                  delay_in = delay_2;
               end
            end
            PH_NACK_LOW: begin
               phase_in = PH_NACK_HIGH;
               delay_in = delay_2;
            end
            PH_NACK_HIGH: begin
               phase_in = PH_STOP_LOW;
               delay_in = delay_4;
            end
            PH_STOP_LOW: begin
               phase_in = PH_STOP_HIGH;
               delay_in = delay_4;
            end
            PH_STOP_HIGH: begin
               phase_in = PH_IDLE;
               delay_in = 10'd0;
               done     = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
               delay_in = 10'd0;
            end
         endcase
      end
   end

   // Result fields for this item.
   always_comb begin
      rsp.scl       = scl;
      rsp.sda_out   = sda;
      rsp.sda_oe    = oe;
      rsp.busy_res  = (phase_in != PH_IDLE);
      rsp.done_res  = done;
      rsp.rd_data   = read_result_in;
      rsp.ack_error = error_in;
   end

   // Bus state, advanced once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         stage_ff       <= ST_DEV_W;
         bit_count_ff   <= 4'd0;
         delay_ff       <= 10'd0;
         shift_ff       <= 8'd0;
         wait_ff        <= 8'd0;
         saved_dev_ff   <= 8'd0;
         saved_reg_ff   <= 8'd0;
         saved_data_ff  <= 8'd0;
         is_read_ff     <= 1'b0;
         read_result_ff <= 8'd0;
         error_ff       <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         stage_ff       <= stage_in;
         bit_count_ff   <= bit_count_in;
         delay_ff       <= delay_in;
         shift_ff       <= shift_in;
         wait_ff        <= wait_in;
         saved_dev_ff   <= saved_dev_in;
         saved_reg_ff   <= saved_reg_in;
         saved_data_ff  <= saved_data_in;
         is_read_ff     <= is_read_in;
         read_result_ff <= read_result_in;
         error_ff       <= error_in;
      end
   end

endmodule

// File: src/i2c_register_master.sv
// Bit-level I2C master for single-register reads and writes.
// Each transfer on the req_ channel is one item: a tick that moves the bus
// waveform on by one step and samples the data line, or a command that opens a
// register read or write while the master is idle (a command while busy counts
// as a tick). Each item produces exactly one transfer on the rsp_ channel with
// the line levels for that step, busy and done flags, the last byte read and
// the acknowledge error flag.
// The result of an item is registered: it is in the output register from the
// clock edge at which the item is accepted. Throughput is one item per cycle while
// the receiver takes results, set by the single bus state register and the output
// register. When the receiver stalls, the held result stays in place and one further
// item is taken only in the cycle in which that result is taken.
// Reset leaves the bus idle, the output register empty, ticks_per_us at one and
// ack_timeout at 250. Configuration is written over csr_ with no wait; the user must
// write it only while no item is in flight, as the block itself does not enforce this.
module i2c_register_master (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2crm_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2crm_pkg::rsp_type  rsp_data,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [7:0]          csr_wdata
);

   logic [7:0]         ticks_per_us_ff;
   logic [7:0]         ack_timeout_ff;
   logic               rsp_valid_ff;
   i2crm_pkg::rsp_type rsp_ff;
   i2crm_pkg::rsp_type rsp_in;
   logic               step;

   // A new item is taken whenever the output register is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_us_ff <= i2crm_pkg::TICKS_PER_US_RESET;
         ack_timeout_ff  <= i2crm_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            i2crm_pkg::CSR_TICKS_PER_US: ticks_per_us_ff <= csr_wdata;
            i2crm_pkg::CSR_ACK_TIMEOUT:  ack_timeout_ff  <= csr_wdata;
            default:                     ;
         endcase
      end
   end

   i2crm_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .req          (req_data),
      .ticks_per_us (ticks_per_us_ff),
      .ack_timeout  (ack_timeout_ff),
      .rsp          (rsp_in)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: tb/i2c_line_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port of the I2C register master.
// It keeps its own model of the bus sequencer, works out the result of every
// accepted request and compares each result transfer with the oldest one due.
module i2c_line_checker
   import i2crm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   output int         mismatch_count,
   output int         pending_results,
   output logic       bus_busy
);

   typedef enum logic [3:0] {
      BUS_IDLE, BUS_START_A, BUS_START_B, BUS_TX_LOW, BUS_TX_HIGH, BUS_TX_TAIL,
      BUS_ACK_SETUP, BUS_ACK_RISE, BUS_ACK_POLL, BUS_RX_LOW, BUS_RX_HIGH,
      BUS_NACK_LOW, BUS_NACK_HIGH, BUS_STOP_LOW, BUS_STOP_HIGH
   } bus_phase_type;

   // Which byte of the register access is on the wire.
   typedef enum logic [2:0] {
      BYTE_DEV_W, BYTE_REG, BYTE_DATA, BYTE_DEV_R, BYTE_READ
   } byte_stage_type;

   logic [7:0]     ticks_per_us;
   logic [7:0]     ack_timeout;
   bus_phase_type  phase;
   byte_stage_type stage;
   logic [3:0]     bit_count;
   logic [9:0]     delay_left;
   logic [7:0]     shift_byte;
   logic [7:0]     wait_count;
   logic [7:0]     saved_dev;
   logic [7:0]     saved_reg;
   logic [7:0]     saved_data;
   logic [7:0]     read_byte;
   logic           is_read;
   logic           ack_failed;
   int             mismatches;
   rsp_type        expected_lines[$];
   rsp_type        want;

   function automatic void clear_bus_model();
      ticks_per_us = TICKS_PER_US_RESET;
      ack_timeout  = ACK_TIMEOUT_RESET;
      phase        = BUS_IDLE;
      stage        = BYTE_DEV_W;
      bit_count    = '0;
      delay_left   = '0;
      shift_byte   = '0;
      wait_count   = '0;
      saved_dev    = '0;
      saved_reg    = '0;
      saved_data   = '0;
      read_byte    = '0;
      is_read      = 1'b0;
      ack_failed   = 1'b0;
   endfunction

   // A delay of some microseconds becomes that many times ticks_per_us ticks.
   function automatic void enter_phase(bus_phase_type target, int units);
      int scale;
      scale      = (ticks_per_us == 8'd0) ? 1 : int'(ticks_per_us);
      phase      = target;
      delay_left = 10'(units * scale);
   endfunction

   function automatic void load_byte(logic [7:0] value);
      shift_byte = value;
      bit_count  = '0;
      enter_phase(BUS_TX_LOW, 2);
   endfunction

   // Moves on to the next byte once the slave has acknowledged.
   function automatic void next_byte();
      case (stage)
         BYTE_DEV_W: begin
            stage = BYTE_REG;
            load_byte(saved_reg);
         end
         BYTE_REG: begin
            if (is_read) begin
               stage      = BYTE_DEV_R;
               shift_byte = saved_dev | READ_BIT;
               bit_count  = '0;
               enter_phase(BUS_START_A, 4);
            end else begin
               stage = BYTE_DATA;
               load_byte(saved_data);
            end
         end
         BYTE_DEV_R: begin
            stage      = BYTE_READ;
            shift_byte = '0;
            bit_count  = '0;
            enter_phase(BUS_RX_LOW, 2);
         end
         default: enter_phase(BUS_STOP_LOW, 4);
      endcase
   endfunction

   // Line levels for the current phase, packed as {scl, sda, oe}.
   function automatic logic [2:0] line_levels();
      logic [2:0] levels;
      levels = 3'b111;
      case (phase)
         BUS_START_B:                          levels = 3'b101;
         BUS_TX_LOW, BUS_TX_TAIL:              levels = {1'b0, shift_byte[7], 1'b1};
         BUS_TX_HIGH:                          levels = {1'b1, shift_byte[7], 1'b1};
         BUS_ACK_SETUP, BUS_RX_LOW:            levels = 3'b010;
         BUS_ACK_RISE, BUS_ACK_POLL, BUS_RX_HIGH: levels = 3'b110;
         BUS_NACK_LOW:                         levels = 3'b011;
         BUS_STOP_LOW:                         levels = 3'b001;
         default: ;
      endcase
      return levels;
   endfunction

   // One tick of the waveform; returns high when the final stop completes.
   function automatic logic bus_advance(logic sda_in);
      if (phase == BUS_ACK_POLL) begin
         if (!sda_in) begin
            next_byte();
         end else if (wait_count >= ack_timeout) begin
            ack_failed = 1'b1;
            enter_phase(BUS_STOP_LOW, 4);
         end else begin
            wait_count = wait_count + 8'd1;
         end
         return 1'b0;
      end
      if (delay_left > 10'd1) begin
         delay_left = delay_left - 10'd1;
         return 1'b0;
      end
      case (phase)
         BUS_START_A: enter_phase(BUS_START_B, 4);
         BUS_START_B: begin
            bit_count = '0;
            enter_phase(BUS_TX_LOW, 2);
         end
         BUS_TX_LOW:  enter_phase(BUS_TX_HIGH, 2);
         BUS_TX_HIGH: enter_phase(BUS_TX_TAIL, 2);
         BUS_TX_TAIL: begin
            shift_byte = {shift_byte[6:0], 1'b0};
            bit_count  = bit_count + 4'd1;
            if (bit_count >= 4'd8) begin
               wait_count = '0;
               enter_phase(BUS_ACK_SETUP, 1);
            end else begin
               enter_phase(BUS_TX_LOW, 2);
            end
         end
         BUS_ACK_SETUP: enter_phase(BUS_ACK_RISE, 1);
         BUS_ACK_RISE: begin
            phase      = BUS_ACK_POLL;
            delay_left = '0;
         end
         BUS_RX_LOW: enter_phase(BUS_RX_HIGH, 1);
         BUS_RX_HIGH: begin
            // The data bit is taken on the last tick of the high interval.
            shift_byte = {shift_byte[6:0], sda_in};
            bit_count  = bit_count + 4'd1;
            if (bit_count >= 4'd8) begin
               read_byte = shift_byte;
               enter_phase(BUS_NACK_LOW, 2);
            end else begin
               enter_phase(BUS_RX_LOW, 2);
            end
         end
         BUS_NACK_LOW:  enter_phase(BUS_NACK_HIGH, 2);
         BUS_NACK_HIGH: enter_phase(BUS_STOP_LOW, 4);
         BUS_STOP_LOW:  enter_phase(BUS_STOP_HIGH, 4);
         BUS_STOP_HIGH: begin
            phase      = BUS_IDLE;
            delay_left = '0;
            return 1'b1;
         end
         default: begin
            phase      = BUS_IDLE;
            delay_left = '0;
         end
      endcase
      return 1'b0;
   endfunction

   // Result of one request. A command is only taken up while the bus is idle.
   function automatic rsp_type bus_step(req_type item);
      rsp_type    result;
      logic [2:0] levels;
      logic       finished;
      finished = 1'b0;
      if (phase == BUS_IDLE && (item.mode == MODE_READ || item.mode == MODE_WRITE)) begin
         saved_dev  = item.dev_addr;
         saved_reg  = item.reg_addr;
         saved_data = item.wr_data;
         is_read    = (item.mode == MODE_READ);
         ack_failed = 1'b0;
         stage      = BYTE_DEV_W;
         shift_byte = item.dev_addr;
         bit_count  = '0;
         wait_count = '0;
         enter_phase(BUS_START_A, 4);
         levels = line_levels();
      end else begin
         levels = line_levels();
         if (phase != BUS_IDLE) finished = bus_advance(item.sda_in);
      end
      result.scl       = levels[2];
      result.sda_out   = levels[1];
      result.sda_oe    = levels[0];
      result.busy_res  = (phase != BUS_IDLE);
      result.done_res  = finished;
      result.rd_data   = read_byte;
      result.ack_error = ack_failed;
      return result;
   endfunction

   task automatic check_field(input string field, input logic [7:0] expected,
                              input logic [7:0] actual);
      if (actual !== expected) begin
         mismatches = mismatches + 1;
         if (mismatches <= 100)
            $display("%0t: %s expected %h, got %h", $time, field, expected, actual);
      end
   endtask

   // Results are checked before the request of the same edge is modelled, as a
   // result can never leave in the cycle its request is taken.
   always @(posedge clock) begin
      if (reset) begin
         clear_bus_model();
         expected_lines.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_lines.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 100)
                  $display("%0t: result expected none, got %h", $time, rsp_data);
            end else begin
               want = expected_lines.pop_front();
               check_field("scl", 8'(want.scl), 8'(rsp_data.scl));
               check_field("sda_out", 8'(want.sda_out), 8'(rsp_data.sda_out));
               check_field("sda_oe", 8'(want.sda_oe), 8'(rsp_data.sda_oe));
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_data.busy_res));
               check_field("done_res", 8'(want.done_res), 8'(rsp_data.done_res));
               check_field("rd_data", want.rd_data, rsp_data.rd_data);
               check_field("ack_error", 8'(want.ack_error), 8'(rsp_data.ack_error));
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_TICKS_PER_US) ticks_per_us = csr_wdata;
            else ack_timeout = csr_wdata;
         end
         if (req_valid && req_ready) expected_lines.push_back(bus_step(req_data));
      end
      pending_results <= expected_lines.size();
      bus_busy        <= (phase != BUS_IDLE);
      mismatch_count  <= mismatches;
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import i2crm_pkg::*;

   // Unused mode value; the master must treat it as a tick.
   localparam logic [1:0] MODE_SPARE      = 2'd3;
   localparam int         WATCHDOG_LIMIT  = 2000;
   localparam int         HOLD_OFF_CYCLES = 300;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we    = 1'b0;
   logic       csr_index = CSR_TICKS_PER_US;
   logic [7:0] csr_wdata = '0;

   int   mismatch_count;
   int   pending_results;
   logic bus_busy;
   int   items_sent   = 0;
   int   quiet_cycles = 0;
   // Percentage of ticks on which the emulated slave leaves the data line high.
   int   ones_pct     = 0;
   logic calm         = 1'b0;

   i2c_register_master uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   i2c_line_checker monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .bus_busy        (bus_busy)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly no gap, sometimes a few cycles, now and then a long one.
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      if (roll < 99) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Offers one request and returns at the edge on which it is taken.
   task automatic send_item(input req_type item);
      int gap;
      if (items_sent % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent <= items_sent + 1;
   endtask

   // Random request: a tick with random operands, or now and then a command.
   task automatic send_noise(input int command_pct);
      req_type item;
      int      roll;
      roll          = $urandom_range(0, 99);
      item.mode     = MODE_TICK;
      if (roll < command_pct)
         item.mode = (roll % 3 == 0) ? MODE_SPARE : (roll % 3 == 1) ? MODE_READ : MODE_WRITE;
      item.dev_addr = 8'($urandom);
      item.reg_addr = 8'($urandom);
      item.wr_data  = 8'($urandom);
      item.sda_in   = ($urandom_range(0, 99) < ones_pct);
      send_item(item);
   endtask

   task automatic send_command(input logic [1:0] mode, input logic [7:0] dev,
                               input logic [7:0] reg_no, input logic [7:0] data);
      req_type item;
      item.mode     = mode;
      item.dev_addr = dev;
      item.reg_addr = reg_no;
      item.wr_data  = data;
      item.sda_in   = 1'(($urandom));
      send_item(item);
   endtask

   // Ticks until the model sees the bus idle again; the flag lags by one request.
   task automatic tick_until_idle();
      do send_noise(0); while (bus_busy);
   endtask

   // One complete register access with the slave behaving as given.
   task automatic run_access(input logic [1:0] mode, input logic [7:0] dev,
                             input logic [7:0] reg_no, input logic [7:0] data,
                             input int slave_ones);
      ones_pct = slave_ones;
      send_command(mode, dev, reg_no, data);
      tick_until_idle();
   endtask

   task automatic wait_quiet();
      repeat (2) @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Lets any access still on the bus finish, then waits for every result.
   task automatic settle_bus();
      req_valid <= 1'b0;
      wait_quiet();
      if (bus_busy) begin
         ones_pct = 0;
         tick_until_idle();
         req_valid <= 1'b0;
         wait_quiet();
      end
   endtask

   task automatic program_bus(input logic [7:0] tick_scale, input logic [7:0] timeout);
      csr_we    <= 1'b1;
      csr_index <= CSR_TICKS_PER_US;
      csr_wdata <= tick_scale;
      @(posedge clock);
      csr_index <= CSR_ACK_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // A slave that acknowledges at once about a third of the time, else a slower one, up to one that rarely answers.
   function automatic int pick_slave();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return 0;
      if (roll < 60) return 10;
      if (roll < 85) return 40;
      return 90;
   endfunction

   task automatic random_phase(input logic [7:0] tick_scale, input logic [7:0] timeout,
                               input int count);
      settle_bus();
      program_bus(tick_scale, timeout);
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0) ones_pct = pick_slave();
         send_noise(8);
      end
   endtask

   // Receiver: bursts of readiness with random gaps, and a long hold-off from
   // time to time while the sender keeps offering.
   initial begin
      int burst;
      int gap;
      int hold_mark;
      hold_mark = 400;
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 40);
         repeat (burst) @(posedge clock);
         if (items_sent >= hold_mark) begin
            gap       = HOLD_OFF_CYCLES;
            hold_mark = hold_mark + 25000;
         end else begin
            gap = idle_gap();
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Watchdog on cycles in which neither channel completes a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: writes at the operand extremes, a read, and a read
      // that the slave never acknowledges, so the old read byte must stay.
      run_access(MODE_WRITE, 8'h00, 8'h00, 8'h00, 0);
      run_access(MODE_WRITE, 8'hFF, 8'hFF, 8'hFF, 0);
      run_access(MODE_READ, 8'hA4, 8'h5A, 8'h00, 40);
      run_access(MODE_READ, 8'h3C, 8'hC3, 8'hFF, 100);

      // Commands arriving while busy and the unused mode are plain ticks.
      ones_pct = 0;
      send_command(MODE_WRITE, 8'h5A, 8'hA5, 8'h96);
      send_command(MODE_READ, 8'hC3, 8'h3C, 8'h69);
      send_command(MODE_SPARE, 8'h81, 8'h7E, 8'h18);
      tick_until_idle();
      send_command(MODE_SPARE, 8'hFF, 8'hFF, 8'hFF);

      // A zero tick scale behaves as one; a zero timeout aborts on the first
      // high sample.
      settle_bus();
      program_bus(8'd0, 8'd0);
      run_access(MODE_WRITE, 8'h42, 8'h24, 8'hE7, 0);
      run_access(MODE_READ, 8'h42, 8'h24, 8'h00, 100);
      run_access(MODE_READ, 8'h43, 8'h11, 8'h00, 40);

      // A slower bus and the longest acknowledge wait, with a slave that
      // never answers.
      settle_bus();
      program_bus(8'd2, 8'd255);
      run_access(MODE_READ, 8'h92, 8'h49, 8'h00, 100);

      random_phase(8'd1, 8'd1, 40);
      random_phase(8'd2, 8'd6, 40);
      random_phase(8'd1, 8'd250, 40);
      random_phase(8'd4, 8'd3, 40);

      req_valid <= 1'b0;
      wait_quiet();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
